// ----- sv/ffha_pkg.sv -----
// Shared types and codes for the first-fit heap allocator.
package ffha_pkg;

	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE  = 1'b1;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_NOMEM   = 2'd1;
	localparam logic [1:0] ST_NULL    = 2'd2;
	localparam logic [1:0] ST_UNKNOWN = 2'd3;

	localparam logic [7:0] REG_HEAP_BASE = 8'd0;
	localparam logic [7:0] REG_HEAP_SIZE = 8'd1;

	typedef struct packed {
		logic        op;
		logic [23:0] req_size;
		logic [31:0] free_addr;
	} ffha_req_t;

	typedef struct packed {
		logic [31:0] payload_addr;
		logic [1:0]  status;
	} ffha_rsp_t;

endpackage

// ----- sv/ffha_ram.sv -----
// Simple dual-port synchronous RAM with registered read data.
module ffha_ram #(
	parameter int W     = 8,
	parameter int DEPTH = 256,
	parameter int AW    = 8
) (
	input  logic          clk,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [W-1:0]  rdata,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [W-1:0]  wdata
);

	logic [W-1:0] mem [DEPTH];
	logic [W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ----- sv/first_fit_heap_allocator_core.sv -----
// Allocate walks the list to the first fit, then may write a split-off block and relink.
// Free walks the list to find the block, then merges it with free neighbors.
// One request at a time; the block table has one read and one write port.
// Results pulse on done for one cycle; the receiver cannot stall.
// Reset clears control; slot 0 and the spare stack come up through flags, no clearing pass.
module first_fit_heap_allocator_core
	import ffha_pkg::*;
#(
	parameter int MAX_BLOCKS   = 256,
	parameter int HEADER_BYTES = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  ffha_req_t   req,
	output logic        done,
	output ffha_rsp_t   rsp,
	input  logic        cfg_we,
	input  logic [7:0]  cfg_idx,
	input  logic [31:0] cfg_wdata
);

	localparam int SW = $clog2(MAX_BLOCKS);
	localparam int LW = SW + 1;
	localparam logic [LW-1:0] NONE = LW'(MAX_BLOCKS);
	localparam logic [LW-1:0] LAST = LW'(MAX_BLOCKS - 1);
	localparam logic [SW-1:0] TOP_SLOT = SW'(MAX_BLOCKS - 1);
	localparam logic [23:0] HB24 = 24'(HEADER_BYTES);
	localparam logic [25:0] HB26 = 26'(HEADER_BYTES);
	localparam logic [31:0] HB32 = 32'(HEADER_BYTES);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_WALK  = 3'd1;
	localparam logic [2:0] S_ANEW  = 3'd2;
	localparam logic [2:0] S_FIX   = 3'd3;
	localparam logic [2:0] S_FWALK = 3'd4;
	localparam logic [2:0] S_FNX   = 3'd5;
	localparam logic [2:0] S_FPV0  = 3'd6;
	localparam logic [2:0] S_FPV   = 3'd7;

	typedef struct packed {
		logic [23:0]   offset;
		logic [23:0]   bytes;
		logic          is_free;
		logic [LW-1:0] next;
		logic [LW-1:0] prev;
	} blk_t;

	localparam int EW = $bits(blk_t);

	logic [2:0]    state_q, state_d;
	logic [LW-1:0] cur_q, cur_d;
	blk_t          cw_q, cw_d;
	logic [23:0]   size_q, size_d;
	logic [31:0]   foff_q, foff_d;
	logic [LW-1:0] nb_q, nb_d;
	logic [LW-1:0] fixv_q, fixv_d;
	logic          fixret_q, fixret_d;
	logic [LW-1:0] count_q, count_d;
	logic [LW-1:0] lw_q, lw_d;
	logic          init_q;
	logic [31:0]   base_q;
	logic [23:0]   hsize_q;
	logic          done_q, done_d;
	ffha_rsp_t     rsp_q, rsp_d;

	logic          ovr_s1, sovr_s1;
	logic [SW-1:0] sidx_s1;
	logic [LW-1:0] rslot_s1;

	logic          re, we, s_re, s_we;
	logic [LW-1:0] raddr, waddr;
	logic [SW-1:0] s_raddr, s_waddr, s_wdata, s_rdata, top;
	blk_t          wdata, rd_blk, e, init_blk;
	logic [EW-1:0] rd_raw;
	logic [LW-1:0] pop_cnt;
	logic [31:0]   grant_addr;

	ffha_ram #(.W(EW), .DEPTH(MAX_BLOCKS), .AW(SW)) u_tbl (
		.clk(clk), .re(re), .raddr(raddr[SW-1:0]), .rdata(rd_raw),
		.we(we), .waddr(waddr[SW-1:0]), .wdata(wdata)
	);

	ffha_ram #(.W(SW), .DEPTH(MAX_BLOCKS), .AW(SW)) u_spare (
		.clk(clk), .re(s_re), .raddr(s_raddr), .rdata(s_rdata),
		.we(s_we), .waddr(s_waddr), .wdata(s_wdata)
	);

	// Slot 0 reads its reset value until it is first written after init.
	always_comb begin
		init_blk.offset  = '0;
		init_blk.bytes   = (hsize_q > HB24) ? hsize_q - HB24 : '0;
		init_blk.is_free = 1'b1;
		init_blk.next    = NONE;
		init_blk.prev    = NONE;
	end

	assign rd_blk = blk_t'(rd_raw);
	assign e      = ovr_s1 ? init_blk : rd_blk;
	// Stack entries below the low-water mark still hold their initial slot numbers.
	assign top        = sovr_s1 ? TOP_SLOT - sidx_s1 : s_rdata;
	assign pop_cnt    = count_q - LW'(1);
	assign grant_addr = base_q + {8'd0, e.offset} + HB32;

	always_comb begin
		state_d  = state_q;
		cur_d    = cur_q;
		cw_d     = cw_q;
		size_d   = size_q;
		foff_d   = foff_q;
		nb_d     = nb_q;
		fixv_d   = fixv_q;
		fixret_d = fixret_q;
		count_d  = count_q;
		lw_d     = lw_q;
		done_d   = 1'b0;
		rsp_d    = rsp_q;
		re       = 1'b0;
		raddr    = cur_q;
		we       = 1'b0;
		waddr    = cur_q;
		wdata    = e;
		s_re     = 1'b0;
		s_raddr  = pop_cnt[SW-1:0];
		s_we     = 1'b0;
		s_waddr  = count_q[SW-1:0];
		s_wdata  = cur_q[SW-1:0];
		case (state_q)
			S_IDLE: begin
				if (start) begin
					size_d = req.req_size;
					foff_d = req.free_addr - base_q - HB32;
					cur_d  = '0;
					raddr  = '0;
					if (req.op == OP_ALLOC) begin
						re      = 1'b1;
						s_re    = 1'b1;
						state_d = S_WALK;
					end else if (req.free_addr == '0) begin
						done_d = 1'b1;
						rsp_d  = '{payload_addr: '0, status: ST_NULL};
					end else begin
						re      = 1'b1;
						state_d = S_FWALK;
					end
				end
			end
			S_WALK: begin
				if (e.is_free && e.bytes >= size_q) begin
					rsp_d = '{payload_addr: grant_addr, status: ST_OK};
					wdata = e;
					wdata.is_free = 1'b0;
					we = 1'b1;
					if (({2'b0, e.bytes} >= {2'b0, size_q} + HB26 + 26'd1) &&
					    (count_q != '0)) begin
						nb_d          = {1'b0, top};
						wdata.next    = {1'b0, top};
						wdata.bytes   = size_q;
						count_d       = pop_cnt;
						lw_d          = (pop_cnt < lw_q) ? pop_cnt : lw_q;
						cw_d.offset   = e.offset + HB24 + size_q;
						cw_d.bytes    = e.bytes - size_q - HB24;
						cw_d.is_free  = 1'b1;
						cw_d.next     = e.next;
						cw_d.prev     = cur_q;
						if (e.next != NONE) begin
							re    = 1'b1;
							raddr = e.next;
						end
						state_d = S_ANEW;
					end else begin
						done_d  = 1'b1;
						state_d = S_IDLE;
					end
				end else if (e.next == NONE) begin
					rsp_d   = '{payload_addr: '0, status: ST_NOMEM};
					done_d  = 1'b1;
					state_d = S_IDLE;
				end else begin
					cur_d = e.next;
					re    = 1'b1;
					raddr = e.next;
				end
			end
			S_ANEW: begin
				we    = 1'b1;
				waddr = nb_q;
				wdata = cw_q;
				if (cw_q.next != NONE) begin
					fixv_d   = nb_q;
					fixret_d = 1'b0;
					state_d  = S_FIX;
				end else begin
					done_d  = 1'b1;
					state_d = S_IDLE;
				end
			end
			S_FIX: begin
				we    = 1'b1;
				waddr = rslot_s1;
				wdata = e;
				wdata.prev = fixv_q;
				if (fixret_q) begin
					state_d = S_FPV0;
				end else begin
					done_d  = 1'b1;
					state_d = S_IDLE;
				end
			end
			S_FWALK: begin
				if ((foff_q[31:24] == 8'd0) && (e.offset == foff_q[23:0])) begin
					rsp_d = '{payload_addr: '0, status: ST_OK};
					cw_d  = e;
					cw_d.is_free = 1'b1;
					if (e.next != NONE) begin
						re      = 1'b1;
						raddr   = e.next;
						state_d = S_FNX;
					end else begin
						state_d = S_FPV0;
					end
				end else if (e.next == NONE) begin
					rsp_d   = '{payload_addr: '0, status: ST_UNKNOWN};
					done_d  = 1'b1;
					state_d = S_IDLE;
				end else begin
					cur_d = e.next;
					re    = 1'b1;
					raddr = e.next;
				end
			end
			S_FNX: begin
				state_d = S_FPV0;
				if (e.is_free) begin
					cw_d.bytes = cw_q.bytes + HB24 + e.bytes;
					cw_d.next  = e.next;
					if (count_q < NONE) begin
						s_we    = 1'b1;
						s_wdata = rslot_s1[SW-1:0];
						count_d = count_q + LW'(1);
					end
					if (e.next != NONE) begin
						re       = 1'b1;
						raddr    = e.next;
						fixv_d   = cur_q;
						fixret_d = 1'b1;
						state_d  = S_FIX;
					end
				end
			end
			S_FPV0: begin
				we    = 1'b1;
				waddr = cur_q;
				wdata = cw_q;
				if (cw_q.prev != NONE) begin
					re      = 1'b1;
					raddr   = cw_q.prev;
					state_d = S_FPV;
				end else begin
					done_d  = 1'b1;
					state_d = S_IDLE;
				end
			end
			S_FPV: begin
				done_d  = 1'b1;
				state_d = S_IDLE;
				if (e.is_free) begin
					we          = 1'b1;
					waddr       = rslot_s1;
					wdata       = e;
					wdata.bytes = e.bytes + HB24 + cw_q.bytes;
					wdata.next  = cw_q.next;
					if (count_q < NONE) begin
						s_we    = 1'b1;
						s_wdata = cur_q[SW-1:0];
						count_d = count_q + LW'(1);
					end
					if (cw_q.next != NONE) begin
						re       = 1'b1;
						raddr    = cw_q.next;
						fixv_d   = rslot_s1;
						fixret_d = 1'b0;
						done_d   = 1'b0;
						state_d  = S_FIX;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			count_q  <= LAST;
			lw_q     <= LAST;
			init_q   <= 1'b1;
			base_q   <= 32'd1048576;
			hsize_q  <= 24'd1048576;
			done_q   <= 1'b0;
			fixret_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			count_q  <= count_d;
			lw_q     <= lw_d;
			done_q   <= done_d;
			fixret_q <= fixret_d;
			if (we && (waddr == '0)) begin
				init_q <= 1'b0;
			end
			if (cfg_we && (cfg_idx == REG_HEAP_BASE)) begin
				base_q <= cfg_wdata;
			end
			if (cfg_we && (cfg_idx == REG_HEAP_SIZE)) begin
				hsize_q <= cfg_wdata[23:0];
				init_q  <= 1'b1;
				count_q <= LAST;
				lw_q    <= LAST;
			end
		end
	end

	always_ff @(posedge clk) begin
		cur_q  <= cur_d;
		cw_q   <= cw_d;
		size_q <= size_d;
		foff_q <= foff_d;
		nb_q   <= nb_d;
		fixv_q <= fixv_d;
		rsp_q  <= rsp_d;
		if (re) begin
			ovr_s1   <= (raddr == '0) && init_q;
			rslot_s1 <= raddr;
		end
		if (s_re) begin
			sovr_s1 <= {1'b0, s_raddr} < lw_q;
			sidx_s1 <= s_raddr;
		end
	end

	assign busy = (state_q != S_IDLE);
	assign done = done_q;
	assign rsp  = rsp_q;

	a_lw_below_count: assert property (@(posedge clk) disable iff (!arst_n)
		lw_q <= count_q)
		else $error("spare stack low-water mark above fill count");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> (state_q == S_IDLE))
		else $error("result strobe while a request is still in progress");

	a_start_progress: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && !cfg_we) |=> (busy || done))
		else $error("accepted request neither started nor answered");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= LAST)
		else $error("spare slot count out of range");

endmodule
